// ===== rtl/vsl_pkg.sv =====
package vsl_pkg;

    localparam int VEL_W           = 16;
    localparam int STEP_W          = 15;
    localparam int CNT_W           = 16;
    localparam int DECEL_FACTOR_Q4 = 24;
    localparam int TIMEOUT_TICKS   = 0;
    localparam int FACTOR_W        = 7;
    localparam int PROD_W          = STEP_W + FACTOR_W;
    localparam int ADDR_W          = 5;
    localparam int DATA_W          = 32;

    // Item kinds on the input channel
    localparam logic FUNC_CMD  = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // Register map, one word per register
    typedef enum logic [2:0] {
        REG_SPEED_MAX_X  = 3'd0,
        REG_SPEED_MIN_X  = 3'd1,
        REG_SPEED_MAX_Y  = 3'd2,
        REG_SPEED_MIN_Y  = 3'd3,
        REG_SPEED_LIM_W  = 3'd4,
        REG_ACCEL_STEP_X = 3'd5,
        REG_ACCEL_STEP_Y = 3'd6,
        REG_ACCEL_STEP_W = 3'd7
    } reg_idx_t;

    // Per-axis limits handed to the slew unit
    typedef struct packed {
        logic        [STEP_W-1:0] accel;
        logic signed [VEL_W-1:0]  lo;
        logic signed [VEL_W-1:0]  hi;
    } axis_cfg_t;

    typedef struct packed {
        logic signed [VEL_W-1:0] x;
        logic signed [VEL_W-1:0] y;
        logic signed [VEL_W-1:0] w;
    } vel_t;

    // Decel step: accel scaled by the Q4 factor, saturated to the step range
    function automatic logic [STEP_W-1:0] decel_step(input logic [STEP_W-1:0] accel);
        logic [PROD_W-1:0] prod;
        logic [PROD_W-1:0] scaled;
        logic [STEP_W-1:0] res;
        prod   = PROD_W'(accel) * PROD_W'(DECEL_FACTOR_Q4);
        scaled = prod >> 4;
        if (scaled > PROD_W'({STEP_W{1'b1}})) begin
            res = {STEP_W{1'b1}};
        end else begin
            res = scaled[STEP_W-1:0];
        end
        return res;
    endfunction

    // Clamp a command to plus or minus a limit
    function automatic logic signed [VEL_W-1:0] clamp_cmd(
        input logic signed [VEL_W-1:0] v,
        input logic        [STEP_W-1:0] lim
    );
        logic signed [VEL_W-1:0] hi;
        logic signed [VEL_W-1:0] lo;
        logic signed [VEL_W-1:0] res;
        hi = signed'({1'b0, lim});
        lo = -hi;
        if (v < lo) begin
            res = lo;
        end else if (v > hi) begin
            res = hi;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

// ===== rtl/vsl_axis.sv =====
module vsl_axis (
    input  vsl_pkg::axis_cfg_t                cfg,
    input  logic signed [vsl_pkg::VEL_W-1:0]  target,
    input  logic signed [vsl_pkg::VEL_W-1:0]  current,
    output logic signed [vsl_pkg::VEL_W-1:0]  vel_next
);

    logic signed [vsl_pkg::VEL_W:0]   delta;
    logic                             opposite;
    logic        [vsl_pkg::STEP_W-1:0] step;
    logic signed [vsl_pkg::VEL_W+1:0] step_s;
    logic signed [vsl_pkg::VEL_W+1:0] moved;
    logic signed [vsl_pkg::VEL_W+1:0] clamped;

    // Pick accel or decel step: decel when the change opposes the motion
    always_comb begin
        delta    = (vsl_pkg::VEL_W+1)'(target) - (vsl_pkg::VEL_W+1)'(current);
        opposite = (delta != '0) && (current != '0) &&
                   (delta[vsl_pkg::VEL_W] != current[vsl_pkg::VEL_W-1]);
        step     = opposite ? vsl_pkg::decel_step(cfg.accel) : cfg.accel;
        step_s   = signed'({3'b000, step});
    end

    // Move toward target by at most one step, then clamp to the output range
    always_comb begin
        if ((vsl_pkg::VEL_W+2)'(delta) > step_s) begin
            moved = (vsl_pkg::VEL_W+2)'(current) + step_s;
        end else if ((vsl_pkg::VEL_W+2)'(delta) < -step_s) begin
            moved = (vsl_pkg::VEL_W+2)'(current) - step_s;
        end else begin
            moved = (vsl_pkg::VEL_W+2)'(target);
        end
        clamped = moved;
        if (clamped < (vsl_pkg::VEL_W+2)'(cfg.lo)) begin
            clamped = (vsl_pkg::VEL_W+2)'(cfg.lo);
        end
        if (clamped > (vsl_pkg::VEL_W+2)'(cfg.hi)) begin
            clamped = (vsl_pkg::VEL_W+2)'(cfg.hi);
        end
        vel_next = clamped[vsl_pkg::VEL_W-1:0];
    end

endmodule

// ===== rtl/velocity_slew_limiter_3axis_core.sv =====
// A tick's result is registered into the output stage and shown on m_vel_*.
// Throughput: one item per cycle while s_ready is high; the state update is
// a single registered pass through the three per-axis slew units. A two-entry
// output stage keeps the input open while one result waits. Commands give no
// result. Reset (aresetn low, synchronous): velocities, targets and tick count
// clear, registers return to their defaults, output stage empties.
module velocity_slew_limiter_3axis_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic        [vsl_pkg::ADDR_W-1:0]   paddr,
    input  logic        [vsl_pkg::DATA_W-1:0]   pwdata,
    output logic        [vsl_pkg::DATA_W-1:0]   prdata,
    output logic                                pready,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_func,
    input  logic signed [vsl_pkg::VEL_W-1:0]    s_cmd_x,
    input  logic signed [vsl_pkg::VEL_W-1:0]    s_cmd_y,
    input  logic signed [vsl_pkg::VEL_W-1:0]    s_cmd_w,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [vsl_pkg::VEL_W-1:0]    m_vel_x,
    output logic signed [vsl_pkg::VEL_W-1:0]    m_vel_y,
    output logic signed [vsl_pkg::VEL_W-1:0]    m_vel_w
);

    localparam int VW = vsl_pkg::VEL_W;
    localparam int SW = vsl_pkg::STEP_W;
    localparam int CW = vsl_pkg::CNT_W;

    // Configuration registers
    logic        [SW-1:0] speed_max_x_reg;
    logic signed [VW-1:0] speed_min_x_reg;
    logic        [SW-1:0] speed_max_y_reg;
    logic signed [VW-1:0] speed_min_y_reg;
    logic        [SW-1:0] speed_lim_w_reg;
    logic        [SW-1:0] accel_step_x_reg;
    logic        [SW-1:0] accel_step_y_reg;
    logic        [SW-1:0] accel_step_w_reg;

    // Smoother state
    vsl_pkg::vel_t   target_reg;
    vsl_pkg::vel_t   current_reg;
    logic [CW-1:0]   ticks_reg;

    // Output stage
    vsl_pkg::vel_t   out_reg;
    vsl_pkg::vel_t   skid_reg;
    logic            out_valid_reg;
    logic            skid_valid_reg;

    logic               cfg_wr;
    vsl_pkg::reg_idx_t  cfg_idx;
    logic               in_xfer;
    logic               cmd_xfer;
    logic               tick_xfer;
    logic [CW-1:0]      ticks_inc;
    logic               timed_out;
    vsl_pkg::vel_t      target_eff;
    vsl_pkg::vel_t      target_cmd;
    vsl_pkg::vel_t      vel_next;
    vsl_pkg::axis_cfg_t cfg_x;
    vsl_pkg::axis_cfg_t cfg_y;
    vsl_pkg::axis_cfg_t cfg_w;
    logic signed [VW-1:0] lim_w_s;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = vsl_pkg::reg_idx_t'(paddr[4:2]);

    // Read back the addressed register
    always_comb begin
        case (cfg_idx)
            vsl_pkg::REG_SPEED_MAX_X:  prdata = 32'(speed_max_x_reg);
            vsl_pkg::REG_SPEED_MIN_X:  prdata = 32'(speed_min_x_reg);
            vsl_pkg::REG_SPEED_MAX_Y:  prdata = 32'(speed_max_y_reg);
            vsl_pkg::REG_SPEED_MIN_Y:  prdata = 32'(speed_min_y_reg);
            vsl_pkg::REG_SPEED_LIM_W:  prdata = 32'(speed_lim_w_reg);
            vsl_pkg::REG_ACCEL_STEP_X: prdata = 32'(accel_step_x_reg);
            vsl_pkg::REG_ACCEL_STEP_Y: prdata = 32'(accel_step_y_reg);
            vsl_pkg::REG_ACCEL_STEP_W: prdata = 32'(accel_step_w_reg);
            default:                   prdata = '0;
        endcase
    end

    // Input handshake: blocked only while both output entries are full
    assign s_ready   = !skid_valid_reg;
    assign in_xfer   = s_valid && s_ready;
    assign cmd_xfer  = in_xfer && (s_func == vsl_pkg::FUNC_CMD);
    assign tick_xfer = in_xfer && (s_func == vsl_pkg::FUNC_TICK);

    // Age the tick counter and check for command timeout
    always_comb begin
        ticks_inc  = (ticks_reg != {CW{1'b1}}) ? ticks_reg + CW'(1) : ticks_reg;
        timed_out  = (vsl_pkg::TIMEOUT_TICKS != 0) &&
                     ({16'b0, ticks_inc} > 32'(vsl_pkg::TIMEOUT_TICKS));
        target_eff = timed_out ? '0 : target_reg;
    end

    // Clamp incoming commands to the symmetric limits
    always_comb begin
        target_cmd.x = vsl_pkg::clamp_cmd(s_cmd_x, speed_max_x_reg);
        target_cmd.y = vsl_pkg::clamp_cmd(s_cmd_y, speed_max_y_reg);
        target_cmd.w = vsl_pkg::clamp_cmd(s_cmd_w, speed_lim_w_reg);
    end

    // Per-axis limits
    always_comb begin
        lim_w_s     = signed'({1'b0, speed_lim_w_reg});
        cfg_x.accel = accel_step_x_reg;
        cfg_x.lo    = speed_min_x_reg;
        cfg_x.hi    = signed'({1'b0, speed_max_x_reg});
        cfg_y.accel = accel_step_y_reg;
        cfg_y.lo    = speed_min_y_reg;
        cfg_y.hi    = signed'({1'b0, speed_max_y_reg});
        cfg_w.accel = accel_step_w_reg;
        cfg_w.lo    = -lim_w_s;
        cfg_w.hi    = lim_w_s;
    end

    vsl_axis u_axis_x (
        .cfg      (cfg_x),
        .target   (target_eff.x),
        .current  (current_reg.x),
        .vel_next (vel_next.x)
    );

    vsl_axis u_axis_y (
        .cfg      (cfg_y),
        .target   (target_eff.y),
        .current  (current_reg.y),
        .vel_next (vel_next.y)
    );

    vsl_axis u_axis_w (
        .cfg      (cfg_w),
        .target   (target_eff.w),
        .current  (current_reg.w),
        .vel_next (vel_next.w)
    );

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_max_x_reg  <= 15'd4096;
            speed_min_x_reg  <= -16'sd4096;
            speed_max_y_reg  <= 15'd4096;
            speed_min_y_reg  <= -16'sd4096;
            speed_lim_w_reg  <= 15'd4096;
            accel_step_x_reg <= 15'd205;
            accel_step_y_reg <= 15'd205;
            accel_step_w_reg <= 15'd205;
        end else if (cfg_wr) begin
            case (cfg_idx)
                vsl_pkg::REG_SPEED_MAX_X:  speed_max_x_reg  <= pwdata[SW-1:0];
                vsl_pkg::REG_SPEED_MIN_X:  speed_min_x_reg  <= signed'(pwdata[VW-1:0]);
                vsl_pkg::REG_SPEED_MAX_Y:  speed_max_y_reg  <= pwdata[SW-1:0];
                vsl_pkg::REG_SPEED_MIN_Y:  speed_min_y_reg  <= signed'(pwdata[VW-1:0]);
                vsl_pkg::REG_SPEED_LIM_W:  speed_lim_w_reg  <= pwdata[SW-1:0];
                vsl_pkg::REG_ACCEL_STEP_X: accel_step_x_reg <= pwdata[SW-1:0];
                vsl_pkg::REG_ACCEL_STEP_Y: accel_step_y_reg <= pwdata[SW-1:0];
                vsl_pkg::REG_ACCEL_STEP_W: accel_step_w_reg <= pwdata[SW-1:0];
                default: ;
            endcase
        end
    end

    // Update targets, velocities and tick counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg  <= '0;
            current_reg <= '0;
            ticks_reg   <= '0;
        end else if (cmd_xfer) begin
            target_reg <= target_cmd;
            ticks_reg  <= '0;
        end else if (tick_xfer) begin
            target_reg  <= target_eff;
            current_reg <= vel_next;
            ticks_reg   <= ticks_inc;
        end
    end

    // Output stage control: advance the spare entry when the head drains
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= tick_xfer;
            end
        end else if (tick_xfer) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Output stage data
    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (tick_xfer) begin
                out_reg <= vel_next;
            end
        end else if (tick_xfer) begin
            skid_reg <= vel_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_vel_x = out_reg.x;
    assign m_vel_y = out_reg.y;
    assign m_vel_w = out_reg.w;

endmodule

// ===== tb/tb_velocity_slew_limiter_3axis_core.sv =====
module tb_velocity_slew_limiter_3axis_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int MAX_PRINTS     = 30;

    typedef struct packed {
        logic                             func;
        logic signed [vsl_pkg::VEL_W-1:0] x;
        logic signed [vsl_pkg::VEL_W-1:0] y;
        logic signed [vsl_pkg::VEL_W-1:0] w;
    } vel_item_t;

    logic                              aclk    = 1'b0;
    logic                              aresetn = 1'b0;
    logic                              psel    = 1'b0;
    logic                              penable = 1'b0;
    logic                              pwrite  = 1'b0;
    logic [vsl_pkg::ADDR_W-1:0]        paddr   = '0;
    logic [vsl_pkg::DATA_W-1:0]        pwdata  = '0;
    logic [vsl_pkg::DATA_W-1:0]        prdata;
    logic                              pready;
    logic                              s_valid = 1'b0;
    logic                              s_ready;
    logic                              s_func  = 1'b0;
    logic signed [vsl_pkg::VEL_W-1:0]  s_cmd_x = '0;
    logic signed [vsl_pkg::VEL_W-1:0]  s_cmd_y = '0;
    logic signed [vsl_pkg::VEL_W-1:0]  s_cmd_w = '0;
    logic                              m_valid;
    logic                              m_ready = 1'b0;
    logic signed [vsl_pkg::VEL_W-1:0]  m_vel_x;
    logic signed [vsl_pkg::VEL_W-1:0]  m_vel_y;
    logic signed [vsl_pkg::VEL_W-1:0]  m_vel_w;

    // Smoother state as the block should hold it
    int lim_max_x = 4096;
    int lim_min_x = -4096;
    int lim_max_y = 4096;
    int lim_min_y = -4096;
    int lim_w     = 4096;
    int step_x    = 205;
    int step_y    = 205;
    int step_w    = 205;
    logic signed [vsl_pkg::VEL_W-1:0] tgt_x = '0, tgt_y = '0, tgt_w = '0;
    logic signed [vsl_pkg::VEL_W-1:0] cur_x = '0, cur_y = '0, cur_w = '0;
    logic [vsl_pkg::CNT_W-1:0]        tick_count = '0;

    vel_item_t     pend_items[$];
    vsl_pkg::vel_t vel_expected[$];

    int n_cmds, n_ticks, n_results, n_writes, n_errors;
    int send_gap, send_burst, stall_left, rcv_burst, hold_left, quiet_cycles;
    int next_hold = 300;
    logic          drv_valid_nxt;
    logic          rdy_nxt;
    vel_item_t     drv_item;
    vsl_pkg::vel_t got_vel, want_vel;

    velocity_slew_limiter_3axis_core DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_func  (s_func),
        .s_cmd_x (s_cmd_x),
        .s_cmd_y (s_cmd_y),
        .s_cmd_w (s_cmd_w),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_vel_x (m_vel_x),
        .m_vel_y (m_vel_y),
        .m_vel_w (m_vel_w)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic int clamp_int(int v, int lo, int hi);
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        return v;
    endfunction

    // Move one axis toward its target; reversing direction uses the decel step
    function automatic int slew_toward(int target, int current, int accel);
        int delta;
        int decel;
        int step;
        delta = target - current;
        decel = accel * vsl_pkg::DECEL_FACTOR_Q4 / 16;
        if (decel > 32767) decel = 32767;
        step = (longint'(delta) * longint'(current) >= 0) ? accel : decel;
        if (delta > step) return current + step;
        if (delta < -step) return current - step;
        return target;
    endfunction

    // Apply one accepted item to the smoother state; ticks queue a velocity
    task automatic advance_smoother(vel_item_t it);
        vsl_pkg::vel_t res;
        if (it.func == vsl_pkg::FUNC_CMD) begin
            tgt_x = 16'(clamp_int(int'(it.x), -lim_max_x, lim_max_x));
            tgt_y = 16'(clamp_int(int'(it.y), -lim_max_y, lim_max_y));
            tgt_w = 16'(clamp_int(int'(it.w), -lim_w, lim_w));
            tick_count = '0;
            n_cmds++;
        end else begin
            if (tick_count != '1) tick_count++;
            if (vsl_pkg::TIMEOUT_TICKS > 0 && int'(tick_count) > vsl_pkg::TIMEOUT_TICKS) begin
                tgt_x = '0;
                tgt_y = '0;
                tgt_w = '0;
            end
            cur_x = 16'(clamp_int(slew_toward(tgt_x, cur_x, step_x), lim_min_x, lim_max_x));
            cur_y = 16'(clamp_int(slew_toward(tgt_y, cur_y, step_y), lim_min_y, lim_max_y));
            cur_w = 16'(clamp_int(slew_toward(tgt_w, cur_w, step_w), -lim_w, lim_w));
            res.x = cur_x;
            res.y = cur_y;
            res.w = cur_w;
            vel_expected.push_back(res);
            n_ticks++;
        end
    endtask

    task automatic report_mismatch(string what, int got, int want);
        n_errors++;
        if (n_errors <= MAX_PRINTS)
            $display("%0t: result %0d %s: got %0d, expected %0d", $time, n_results, what,
                     got, want);
    endtask

    // Mostly back to back, some short gaps, a few long ones, and idle-free bursts
    function automatic int next_gap(inout int burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if (r < 2) begin
            burst = $urandom_range(20, 80);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Register write over APB; upper data bits carry noise the block must drop
    task automatic write_reg(vsl_pkg::reg_idx_t idx, int value);
        logic [vsl_pkg::DATA_W-1:0] data;
        data = {16'($urandom()), 16'(value)};
        if (idx != vsl_pkg::REG_SPEED_MIN_X && idx != vsl_pkg::REG_SPEED_MIN_Y)
            data[15] = 1'($urandom_range(0, 1));
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= vsl_pkg::ADDR_W'(4 * int'(idx));
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            vsl_pkg::REG_SPEED_MAX_X:  lim_max_x = int'(data[14:0]);
            vsl_pkg::REG_SPEED_MIN_X:  lim_min_x = int'(signed'(data[15:0]));
            vsl_pkg::REG_SPEED_MAX_Y:  lim_max_y = int'(data[14:0]);
            vsl_pkg::REG_SPEED_MIN_Y:  lim_min_y = int'(signed'(data[15:0]));
            vsl_pkg::REG_SPEED_LIM_W:  lim_w     = int'(data[14:0]);
            vsl_pkg::REG_ACCEL_STEP_X: step_x    = int'(data[14:0]);
            vsl_pkg::REG_ACCEL_STEP_Y: step_y    = int'(data[14:0]);
            vsl_pkg::REG_ACCEL_STEP_W: step_w    = int'(data[14:0]);
            default: ;
        endcase
        n_writes++;
    endtask

    function automatic int pick_limit();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return 0;
        if (r < 18) return 32767;
        if (r < 60) return $urandom_range(1, 8192);
        return $urandom_range(1, 32767);
    endfunction

    function automatic int pick_floor();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return -32768;
        if (r < 18) return 0;
        if (r < 23) return $urandom_range(1, 2000);
        return -int'($urandom_range(0, 32768));
    endfunction

    function automatic int pick_step();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return 0;
        if (r < 16) return 32767;
        if (r < 20) return 21845;
        if (r < 24) return 21846;
        if (r < 85) return $urandom_range(1, 3000);
        return $urandom_range(1, 32767);
    endfunction

    task automatic randomize_limits();
        write_reg(vsl_pkg::REG_SPEED_MAX_X, pick_limit());
        write_reg(vsl_pkg::REG_SPEED_MIN_X, pick_floor());
        write_reg(vsl_pkg::REG_SPEED_MAX_Y, pick_limit());
        write_reg(vsl_pkg::REG_SPEED_MIN_Y, pick_floor());
        write_reg(vsl_pkg::REG_SPEED_LIM_W, pick_limit());
        write_reg(vsl_pkg::REG_ACCEL_STEP_X, pick_step());
        write_reg(vsl_pkg::REG_ACCEL_STEP_Y, pick_step());
        write_reg(vsl_pkg::REG_ACCEL_STEP_W, pick_step());
    endtask

    function automatic logic signed [vsl_pkg::VEL_W-1:0] rand_vel(int lim);
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) return 16'sh7FFF;
        if (r < 8) return 16'sh8000;
        if (r < 12) return 16'(lim);
        if (r < 16) return 16'(-lim);
        if (r < 65) return 16'(int'($urandom_range(0, 2 * lim)) - lim);
        return 16'($urandom());
    endfunction

    task automatic push_item(logic func, logic signed [vsl_pkg::VEL_W-1:0] x,
                             logic signed [vsl_pkg::VEL_W-1:0] y,
                             logic signed [vsl_pkg::VEL_W-1:0] w);
        vel_item_t it;
        it.func = func;
        it.x    = x;
        it.y    = y;
        it.w    = w;
        pend_items.push_back(it);
    endtask

    // Commands with mostly in-range targets, then runs of ticks to chase them
    task automatic push_random(int n);
        repeat (n) begin
            if ($urandom_range(0, 99) < 30)
                push_item(vsl_pkg::FUNC_CMD, rand_vel(lim_max_x), rand_vel(lim_max_y),
                          rand_vel(lim_w));
            else
                push_item(vsl_pkg::FUNC_TICK, 16'($urandom()), 16'($urandom()),
                          16'($urandom()));
        end
    endtask

    // Wait for the pipe to drain, then let the last command settle
    task automatic wait_idle();
        do @(negedge aclk);
        while (pend_items.size() != 0 || s_valid || vel_expected.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    // Driver: retire the accepted transfer, then offer the next item after its gap
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = 0;
        end else begin
            drv_valid_nxt = s_valid;
            if (s_valid && s_ready) begin
                advance_smoother(drv_item);
                drv_valid_nxt = 1'b0;
            end
            if (!drv_valid_nxt) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pend_items.size() > 0) begin
                    drv_item = pend_items.pop_front();
                    s_func  <= drv_item.func;
                    s_cmd_x <= drv_item.x;
                    s_cmd_y <= drv_item.y;
                    s_cmd_w <= drv_item.w;
                    drv_valid_nxt = 1'b1;
                    send_gap = next_gap(send_burst);
                end
            end
            s_valid <= drv_valid_nxt;
        end
    end

    // Monitor: check each result, then pick the next ready with stalls and long holds
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                n_results++;
                got_vel.x = m_vel_x;
                got_vel.y = m_vel_y;
                got_vel.w = m_vel_w;
                if (vel_expected.size() == 0) begin
                    report_mismatch("unexpected vel_x", got_vel.x, 0);
                end else begin
                    want_vel = vel_expected.pop_front();
                    if (got_vel.x !== want_vel.x) report_mismatch("vel_x", got_vel.x, want_vel.x);
                    if (got_vel.y !== want_vel.y) report_mismatch("vel_y", got_vel.y, want_vel.y);
                    if (got_vel.w !== want_vel.w) report_mismatch("vel_w", got_vel.w, want_vel.w);
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy_nxt = 1'b0;
            end else if (n_results >= next_hold) begin
                // hold off long enough for the output stage to fill and stall the input
                hold_left = HOLD_CYCLES;
                next_hold += 700;
                rdy_nxt = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rdy_nxt = 1'b0;
            end else begin
                rdy_nxt = 1'b1;
                stall_left = next_gap(rcv_burst);
            end
            m_ready <= rdy_nxt;
        end
    end

    // Watchdog: end the run if no transfer happens for too long
    always @(posedge aclk) begin
        if (!aresetn) begin
            quiet_cycles = 0;
        end else if ((s_valid && s_ready) || (m_valid && m_ready) ||
                     (psel && penable && pwrite && pready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("** velocity_slew_limiter_3axis_core: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Defaults: ramp from rest toward clamped extremes, then reverse
        push_item(vsl_pkg::FUNC_TICK, 16'sh0000, 16'sh0000, 16'sh0000);
        push_item(vsl_pkg::FUNC_CMD, 16'sh7FFF, 16'sh8000, 16'shFFFF);
        push_item(vsl_pkg::FUNC_TICK, 16'sh7FFF, 16'sh8000, 16'shFFFF);
        push_item(vsl_pkg::FUNC_TICK, 16'sh5555, 16'shAAAA, 16'sh0F0F);
        push_item(vsl_pkg::FUNC_TICK, 16'shFFFF, 16'sh0000, 16'sh8000);
        push_item(vsl_pkg::FUNC_CMD, 16'sh8000, 16'sh7FFF, 16'sh0000);
        push_item(vsl_pkg::FUNC_TICK, 16'sh0000, 16'sh0000, 16'sh0000);
        push_item(vsl_pkg::FUNC_TICK, 16'sh1234, 16'shFEDC, 16'sh7FFF);
        wait_idle();

        // Full-scale steps: decel saturates, zero accel on y, y pinned to zero
        write_reg(vsl_pkg::REG_SPEED_MAX_X, 32767);
        write_reg(vsl_pkg::REG_SPEED_MIN_X, -32768);
        write_reg(vsl_pkg::REG_SPEED_MAX_Y, 0);
        write_reg(vsl_pkg::REG_SPEED_MIN_Y, 0);
        write_reg(vsl_pkg::REG_SPEED_LIM_W, 32767);
        write_reg(vsl_pkg::REG_ACCEL_STEP_X, 32767);
        write_reg(vsl_pkg::REG_ACCEL_STEP_Y, 0);
        write_reg(vsl_pkg::REG_ACCEL_STEP_W, 21845);
        push_item(vsl_pkg::FUNC_CMD, 16'sh7FFF, 16'sh0064, 16'sh8000);
        push_item(vsl_pkg::FUNC_TICK, 16'sh0000, 16'sh0000, 16'sh0000);
        push_item(vsl_pkg::FUNC_CMD, 16'sh8000, 16'sh8000, 16'sh7FFF);
        push_item(vsl_pkg::FUNC_TICK, 16'sh0000, 16'sh0000, 16'sh0000);
        push_item(vsl_pkg::FUNC_TICK, 16'sh0000, 16'sh0000, 16'sh0000);
        wait_idle();

        // Floor above ceiling on x (ceiling wins), zero angular limit, decel just over max
        write_reg(vsl_pkg::REG_SPEED_MAX_X, 50);
        write_reg(vsl_pkg::REG_SPEED_MIN_X, 100);
        write_reg(vsl_pkg::REG_SPEED_MAX_Y, 32767);
        write_reg(vsl_pkg::REG_SPEED_MIN_Y, -32768);
        write_reg(vsl_pkg::REG_SPEED_LIM_W, 0);
        write_reg(vsl_pkg::REG_ACCEL_STEP_Y, 21846);
        push_item(vsl_pkg::FUNC_CMD, 16'sh03E8, 16'sh8000, 16'sh0005);
        push_item(vsl_pkg::FUNC_TICK, 16'sh0000, 16'sh0000, 16'sh0000);
        push_item(vsl_pkg::FUNC_CMD, 16'sh0000, 16'sh7FFF, 16'shFFFB);
        push_item(vsl_pkg::FUNC_TICK, 16'sh0000, 16'sh0000, 16'sh0000);
        push_item(vsl_pkg::FUNC_TICK, 16'sh0000, 16'sh0000, 16'sh0000);
        wait_idle();

        // Random phases, each under its own register setting
        for (int p = 0; p < 8; p++) begin
            randomize_limits();
            push_random(215);
            wait_idle();
        end
        repeat (6) @(posedge aclk);

        $display("covered %0d commands and %0d ticks over %0d register writes",
                 n_cmds, n_ticks, n_writes);
        $display("checked %0d velocity results, %0d mismatches", n_results, n_errors);
        if (n_errors == 0 && vel_expected.size() == 0) begin
            $display("** velocity_slew_limiter_3axis_core: PASSED **");
        end else begin
            $display("** velocity_slew_limiter_3axis_core: FAILED **");
        end
        $finish;
    end

endmodule
